[hw/rtl/fis_pkg.sv]
package fis_pkg;

    typedef enum logic [1:0] {
        CMD_S32 = 2'd0,
        CMD_U32 = 2'd1,
        CMD_U16 = 2'd2,
        CMD_S16 = 2'd3
    } cmd_t;

    localparam int EXP_BIAS = 127;

    typedef struct packed {
        logic        neg;
        logic        big;
        logic        nan;
        logic [31:0] mag;
    } conv_t;

endpackage

[hw/rtl/fis_core.sv]
module fis_core
    import fis_pkg::*;
(
    input  logic [1:0]  command,
    input  logic [31:0] value_bits,
    output logic [31:0] result_bits
);

    conv_t       c;
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [23:0] mant;
    logic [4:0]  e;
    logic [54:0] shifted;

    assign expo = value_bits[30:23];
    assign frac = value_bits[22:0];
    assign mant = {1'b1, frac};
    assign e    = 5'(expo - 8'(EXP_BIAS));
    // mantissa with its hidden one at bit 23, shifted left by e; integer part from bit 23 up
    assign shifted = {31'd0, mant} << e;

    always_comb
    begin
        c.neg = value_bits[31];
        c.nan = (expo == 8'hFF) && (frac != 23'd0);
        c.big = (expo == 8'hFF) || (expo >= 8'(EXP_BIAS + 32));
        if (expo < 8'(EXP_BIAS) || c.big)
            c.mag = 32'd0;
        else
            c.mag = shifted[54:23];
    end

    always_comb
    begin
        result_bits = 32'd0;
        if (!c.nan)
        begin
            case (cmd_t'(command))
                CMD_S32:
                    if (c.big || c.mag[31])
                        result_bits = c.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    else
                        result_bits = c.neg ? 32'd0 - c.mag : c.mag;
                CMD_U32:
                    if (!c.neg)
                        result_bits = c.big ? 32'hFFFF_FFFF : c.mag;
                CMD_U16:
                    if (!c.neg)
                        result_bits = (c.big || c.mag >= 32'h0000_FFFF)
                                      ? 32'h0000_FFFF : c.mag;
                default:
                    if (c.neg)
                        result_bits = (c.big || c.mag >= 32'h0000_8000)
                                      ? 32'hFFFF_8000 : 32'd0 - c.mag;
                    else
                        result_bits = (c.big || c.mag >= 32'h0000_7FFF)
                                      ? 32'h0000_7FFF : c.mag;
            endcase
        end
    end

endmodule

[hw/rtl/float_to_int_saturate_unit.sv]
// channel  direction  tdata (low bit up)                    tuser
// s_axis   in         [1:0] command, [33:2] value_bits      -
// m_axis   out        [31:0] result_bits                    -
// one request per cycle while the result is not stalled; passes the input register, then the result register
// rst_n clears only the valid flags; data registers are not reset
// a stalled result holds; the input stage refills as soon as the result moves
module float_to_int_saturate_unit
    import fis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // command[1:0], value_bits[33:2], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // result_bits[31:0]
);

    logic        in_vld_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] val_reg;
    logic        out_vld_reg;
    logic [31:0] res_reg;
    logic [31:0] res_next;
    logic        adv;

    fis_core u_core (
        .command     (cmd_reg),
        .value_bits  (val_reg),
        .result_bits (res_next)
    );

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_vld_reg <= s_axis_tvalid;
            if (adv)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            cmd_reg <= s_axis_tdata[1:0];
            val_reg <= s_axis_tdata[33:2];
        end
        if (adv && in_vld_reg)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = res_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && adv |=> out_vld_reg)
        else $error("request lost between stages");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_axis_tready)
        else $error("input blocked with empty output");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import fis_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    float_to_int_saturate_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    typedef struct {
        cmd_t        cmd;
        logic [31:0] bits;
        logic        known;
        logic [31:0] res;
    } stim_row_t;

    logic [31:0] expected_results[$];
    int          errors = 0;
    bit          rx_hold = 0;
    bit          rx_calm = 0;
    bit          tx_calm = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // truncating saturating conversion on the raw bit pattern
    function automatic logic [31:0] convert_float(cmd_t cmd, logic [31:0] bits);
        logic        neg;
        logic [7:0]  expo;
        logic [22:0] frac;
        logic        big;
        logic [63:0] mag;
        logic [63:0] mant;
        int          e;
        neg  = bits[31];
        expo = bits[30:23];
        frac = bits[22:0];
        big  = 1'b0;
        mag  = '0;
        mant = {40'd0, 1'b1, frac};
        if (expo == 8'hFF && frac != 0)
            return 32'd0;
        if (expo == 8'hFF)
            big = 1'b1;
        else if (expo >= 8'd159)
            big = 1'b1;
        else if (expo >= 8'd127)
        begin
            e = int'(expo) - EXP_BIAS;
            mag = (e >= 23) ? (mant << (e - 23)) : (mant >> (23 - e));
        end
        case (cmd)
            CMD_S32:
                if (neg)
                    return (big || mag >= 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
                else
                    return (big || mag >= 64'h8000_0000) ? 32'h7FFF_FFFF : mag[31:0];
            CMD_U32:
                if (neg)
                    return 32'd0;
                else
                    return (big || mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag[31:0];
            CMD_U16:
                if (neg)
                    return 32'd0;
                else
                    return (big || mag >= 64'hFFFF) ? 32'h0000_FFFF : mag[31:0];
            default:
                if (neg)
                    return (big || mag >= 64'h8000) ? 32'hFFFF_8000 : -mag[31:0];
                else
                    return (big || mag >= 64'h7FFF) ? 32'h0000_7FFF : mag[31:0];
        endcase
    endfunction

    function automatic logic [31:0] random_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[30:23] = 8'hFF;
            1: v[30:23] = 8'd0;
            2: v[30:23] = 8'($urandom_range(140, 165));
            3: v[30:23] = 8'($urandom_range(120, 145));
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_request(cmd_t cmd, logic [31:0] bits);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, bits, cmd};
        expected_results.push_back(convert_float(cmd, bits));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // now and then, after about 23 percent of requests, the sender goes idle
        if (!tx_calm && $urandom_range(0, 99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // receiver side
    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= !rx_hold && (rx_calm || $urandom_range(0, 99) >= 19);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                logic [31:0] want;
                want = expected_results.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $display("%0t: result_bits expected %h actual %h",
                             $time, want, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t r;
        cmd_t      c;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{CMD_S32, 32'h7FC0_0000, 1, 32'd0});          // nan
        rows.push_back('{CMD_S16, 32'hFFFF_FFFF, 1, 32'd0});          // negative nan
        rows.push_back('{CMD_S32, 32'h7F80_0000, 1, 32'h7FFF_FFFF});  // +inf
        rows.push_back('{CMD_S32, 32'hFF80_0000, 1, 32'h8000_0000});  // -inf
        rows.push_back('{CMD_U32, 32'h7F80_0000, 1, 32'hFFFF_FFFF});
        rows.push_back('{CMD_U32, 32'hFF80_0000, 1, 32'd0});
        rows.push_back('{CMD_U16, 32'h7F80_0000, 1, 32'h0000_FFFF});
        rows.push_back('{CMD_S16, 32'h7F80_0000, 1, 32'h0000_7FFF});
        rows.push_back('{CMD_S16, 32'hFF80_0000, 1, 32'hFFFF_8000});
        rows.push_back('{CMD_S32, 32'h0000_0000, 1, 32'd0});          // zero
        rows.push_back('{CMD_S32, 32'h8000_0000, 1, 32'd0});          // negative zero
        rows.push_back('{CMD_U32, 32'h0000_0001, 1, 32'd0});          // subnormal
        rows.push_back('{CMD_S32, 32'h0080_0000, 1, 32'd0});          // smallest normal
        rows.push_back('{CMD_S32, 32'h3F80_0000, 1, 32'd1});
        rows.push_back('{CMD_S32, 32'hBF80_0000, 1, 32'hFFFF_FFFF});
        rows.push_back('{CMD_S32, 32'h4F00_0000, 1, 32'h7FFF_FFFF});  // 2^31
        rows.push_back('{CMD_S32, 32'hCF00_0000, 1, 32'h8000_0000});  // -2^31
        rows.push_back('{CMD_U32, 32'h4F7F_FFFF, 0, 32'd0});
        rows.push_back('{CMD_U32, 32'h4F80_0000, 1, 32'hFFFF_FFFF});  // 2^32
        rows.push_back('{CMD_U16, 32'h477F_FF00, 1, 32'h0000_FFFF});  // 65535
        rows.push_back('{CMD_U16, 32'h477F_FE00, 0, 32'd0});
        rows.push_back('{CMD_S16, 32'h46FF_FE00, 1, 32'h0000_7FFF});  // 32767
        rows.push_back('{CMD_S16, 32'hC700_0000, 1, 32'hFFFF_8000});  // -32768
        rows.push_back('{CMD_S16, 32'hC6FF_FE00, 0, 32'd0});
        rows.push_back('{CMD_U32, 32'h7F7F_FFFF, 1, 32'hFFFF_FFFF});

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.known && convert_float(r.cmd, r.bits) !== r.res)
            begin
                $display("%0t: table row %0d expected %h actual %h", $time, i,
                         r.res, convert_float(r.cmd, r.bits));
                errors++;
            end
            send_request(r.cmd, r.bits);
        end

        for (int n = 0; n < 1650; n++)
        begin
            c = cmd_t'($urandom_range(0, 3));
            if (n == 300)
            begin
                // long receiver stall while requests keep coming
                fork
                    begin
                        rx_hold = 1;
                        repeat (60) @(posedge clk);
                        rx_hold = 0;
                    end
                join_none
            end
            if (n == 700)
            begin
                s_axis_tvalid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
            rx_calm = (n >= 1000 && n < 1200);
            tx_calm = rx_calm;
            send_request(c, random_float());
        end
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
